// ===== hw/rtl/lev_pkg.sv =====
package lev_pkg;

  // Default bound on either string, in bytes
  localparam int MAX_LEN_DEF = 64;

  localparam int DIST_W   = 7;
  localparam int STATUS_W = 2;
  localparam int OP_W     = 2;
  localparam int SYM_W    = 8;

  localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
  localparam logic [OP_W-1:0] OP_PROCESS = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ORDER    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FIN
  } lev_state_t;

  // Controller to datapath
  typedef struct packed {
    logic append_wr;   // store symbol at the end of the second string
    logic set_ovf;     // flag a length overflow
    logic set_order;   // flag a late second-string byte
    logic proc_init;   // latch symbol, seed the row walk
    logic issue;       // read the next row column
    logic count_first; // one more first-string byte done
    logic fin_read;    // read the last row entry
    logic emit;        // present the result
    logic clear;       // reset the pair state
  } lev_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic len_zero;    // second string empty
    logic sb_full;     // second string at its bound
    logic fc_zero;     // no first-string byte yet
    logic fc_full;     // first string at its bound
    logic issue_last;  // next issue reads the last column
  } lev_stat_t;

endpackage

// ===== hw/rtl/lev_ctrl.sv =====
module lev_ctrl
  import lev_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [OP_W-1:0] operation,
  input  lev_stat_t       stat,
  output lev_cmd_t        cmd,
  output logic            busy,
  output logic            done
);

  lev_state_t state;
  lev_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (operation)
            OP_APPEND: begin
              if (!stat.fc_zero) begin
                cmd.set_order = 1'b1;
              end else if (stat.sb_full) begin
                cmd.set_ovf = 1'b1;
              end else begin
                cmd.append_wr = 1'b1;
              end
            end
            OP_PROCESS: begin
              if (stat.fc_full) begin
                cmd.set_ovf = 1'b1;
              end else if (stat.len_zero) begin
                cmd.count_first = 1'b1;
              end else begin
                cmd.proc_init = 1'b1;
                state_next    = ST_WALK;
              end
            end
            OP_FINISH: begin
              cmd.fin_read = 1'b1;
              state_next   = ST_FIN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        cmd.issue = 1'b1;
        if (stat.issue_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.count_first = 1'b1;
        state_next      = ST_IDLE;
      end
      ST_FIN: begin
        cmd.emit   = 1'b1;
        cmd.clear  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = cmd.emit;

  a_drain_after_walk: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> $past(state) == ST_WALK)
    else $error("drain entered without a row walk");

  a_single_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> !cmd.emit)
    else $error("result emitted twice");

endmodule

// ===== hw/rtl/lev_dpath.sv =====
module lev_dpath
  import lev_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [SYM_W-1:0]    symbol,
  input  lev_cmd_t            cmd,
  output lev_stat_t           stat,
  output logic [DIST_W-1:0]   distance,
  output logic [STATUS_W-1:0] status
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  // Row entry col (1..MAX_LEN) lives at address col-1; entry 0 always equals first_count
  logic [SYM_W-1:0] sb_mem [MAX_LEN];
  logic [CW-1:0]    dp_mem [MAX_LEN];

  logic [CW-1:0]    sec_len;
  logic [CW-1:0]    first_count;
  logic             ovf;
  logic             order;

  logic [SYM_W-1:0] sym_q;
  logic [CW-1:0]    left;
  logic [CW-1:0]    diag;
  logic [AW-1:0]    issue_addr;
  logic             rd_valid;
  logic [AW-1:0]    rd_addr_q;
  logic [SYM_W-1:0] sb_q;
  logic [CW-1:0]    dp_q;

  logic [AW-1:0]    rd_addr;
  logic [CW-1:0]    len_m1;
  logic [CW-1:0]    up_v;
  logic [CW:0]      sub_c;
  logic [CW:0]      ins_c;
  logic [CW:0]      del_c;
  logic [CW:0]      best_c;
  logic [CW-1:0]    dist_full;

  assign len_m1  = sec_len - CW'(1);
  assign rd_addr = cmd.fin_read ? len_m1[AW-1:0] : issue_addr;

  assign stat.len_zero   = (sec_len == '0);
  assign stat.sb_full    = (sec_len == CW'(MAX_LEN));
  assign stat.fc_zero    = (first_count == '0);
  assign stat.fc_full    = (first_count == CW'(MAX_LEN));
  assign stat.issue_last = ((CW'(issue_addr) + CW'(1)) == sec_len);

  // Until the first row step the stored row is unwritten: entry col reads as col
  always_comb begin
    up_v   = stat.fc_zero ? (CW'(rd_addr_q) + CW'(1)) : dp_q;
    sub_c  = {1'b0, diag} + (CW + 1)'(sym_q != sb_q);
    ins_c  = {1'b0, left} + (CW + 1)'(1);
    del_c  = {1'b0, up_v} + (CW + 1)'(1);
    best_c = sub_c;
    if (ins_c < best_c) begin
      best_c = ins_c;
    end
    if (del_c < best_c) begin
      best_c = del_c;
    end
  end

  always_ff @(posedge clk) begin
    sb_q <= sb_mem[rd_addr];
    dp_q <= dp_mem[rd_addr];
    if (cmd.append_wr) begin
      sb_mem[sec_len[AW-1:0]] <= symbol;
    end
    if (rd_valid) begin
      dp_mem[rd_addr_q] <= best_c[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= issue_addr;
    if (cmd.proc_init) begin
      sym_q      <= symbol;
      left       <= first_count + CW'(1);
      diag       <= first_count;
      issue_addr <= '0;
    end else begin
      if (cmd.issue) begin
        issue_addr <= issue_addr + AW'(1);
      end
      if (rd_valid) begin
        left <= best_c[CW-1:0];
        diag <= up_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid    <= 1'b0;
      sec_len     <= '0;
      first_count <= '0;
      ovf         <= 1'b0;
      order       <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
      if (cmd.clear) begin
        sec_len     <= '0;
        first_count <= '0;
        ovf         <= 1'b0;
        order       <= 1'b0;
      end else begin
        if (cmd.append_wr) begin
          sec_len <= sec_len + CW'(1);
        end
        if (cmd.count_first) begin
          first_count <= first_count + CW'(1);
        end
        if (cmd.set_ovf) begin
          ovf <= 1'b1;
        end
        if (cmd.set_order) begin
          order <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (stat.len_zero) begin
      dist_full = first_count;
    end else if (stat.fc_zero) begin
      dist_full = sec_len;
    end else begin
      dist_full = dp_q;
    end
  end

  assign distance = DIST_W'(dist_full);
  assign status   = ovf ? STATUS_OVERFLOW : (order ? STATUS_ORDER : STATUS_OK);

  a_best_bounded: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> best_c <= (CW + 1)'(MAX_LEN))
    else $error("row entry beyond string bound");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    sec_len <= CW'(MAX_LEN) && first_count <= CW'(MAX_LEN))
    else $error("string length counter beyond bound");

  a_second_frozen: assert property (@(posedge clk) disable iff (rst)
    (first_count != '0 && !cmd.clear) |=> $stable(sec_len))
    else $error("second string grew after first-string bytes");

endmodule

// ===== hw/rtl/levenshtein_distance.sv =====
// Channel   Direction  Handshake             Payload
// command   in         start high, busy low  operation, symbol
// result    out        done (one cycle)      distance, status
//
// Append leaves busy low.
// Process with a non-empty second string holds busy after the transfer: the row
//   walk reads one column per cycle from the single-read row memory, plus a drain
//   state.
// Finish raises busy; done pulses while busy is high, then the pair clears.
// Synchronous active-high rst clears control state; no memory clearing pass.
// The receiver cannot stall: done is a one-cycle strobe.
module levenshtein_distance
  import lev_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     operation,
  input  logic [SYM_W-1:0]    symbol,
  output logic                done,
  output logic [DIST_W-1:0]   distance,
  output logic [STATUS_W-1:0] status
);

  // Command and status between sequencer and row datapath
  lev_cmd_t  cmd;
  lev_stat_t stat;

  // Sequencer: decode each transfer, pace the row walk, pulse the result
  lev_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  // Datapath: string store, distance row memory, counters and flags
  lev_dpath #(
    .MAX_LEN (MAX_LEN)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .symbol   (symbol),
    .cmd      (cmd),
    .stat     (stat),
    .distance (distance),
    .status   (status)
  );

endmodule
